/* rtl/page_map_allocator_defines.svh */
// ----------------------------------------------------------------------------
// page_map_allocator_defines.svh
// assertion macros shared by the page map allocator
// ----------------------------------------------------------------------------
`ifndef PAGE_MAP_ALLOCATOR_DEFINES_SVH
`define PAGE_MAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page map allocator check failed");

// next-cycle implication, checked outside reset
`define PMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page map allocator check failed");

`endif

/* rtl/pma_pkg.sv */
// ----------------------------------------------------------------------------
// pma_pkg
// shared types and constants of the page map allocator
// ----------------------------------------------------------------------------
package pma_pkg;

    localparam int PAGE_COUNT_DEF     = 1024;
    localparam int PAGE_SIZE_LOG2_DEF = 12;

    // request codes
    typedef enum logic [1:0] {
        REQ_MAP     = 2'd0,
        REQ_UNMAP   = 2'd1,
        REQ_PROTECT = 2'd2
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NOSPACE = 2'd1,
        STS_INVALID = 2'd2,
        STS_PROT    = 2'd3
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MF_RD,
        S_MF_EV,
        S_MAP_POST,
        S_FF_RD,
        S_FF_EV,
        S_PCHK,
        S_MW,
        S_RG_RD,
        S_RG_EV,
        S_RG_POST,
        S_RW_RD,
        S_RW_EV,
        S_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    clr_wr;
        logic    ptr_start;
        logic    ptr_one;
        logic    ptr_inc;
        logic    ok_set;
        logic    ok_clr;
        logic    flags_clr;
        logic    reg_eval;
        logic    ff_eval;
        logic    map_wr;
        logic    reg_wr;
        logic    res_set;
        logic    res_addr;
        status_t res_status;
        logic    push;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] req_type;
        logic       size_zero;
        logic       inrange;
        logic       end_hit;
        logic       ptr_last;
        logic       ptr_at_n;
        logic       entry_valid;
        logic       ok;
        logic       start_zero;
        logic       anywhere;
        logic       overwrite;
        logic       prot_ok;
        logic       not_mapped;
        logic       prot_fail;
        logic       ff_found;
        logic       out_free;
    } sts_t;

endpackage

/* rtl/pma_datapath.sv */
// ----------------------------------------------------------------------------
// pma_datapath
// page table memory, walk pointer, search state and result register
// ----------------------------------------------------------------------------
module pma_datapath #(
    parameter int PAGE_COUNT     = pma_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SIZE_LOG2 = pma_pkg::PAGE_SIZE_LOG2_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    req_type,
    input  logic [31:0]   address,
    input  logic [31:0]   size,
    input  logic [31:0]   align_mask,
    input  logic          anywhere,
    input  logic          overwrite,
    input  logic [2:0]    protect,
    input  logic [2:0]    max_protect,
    input  logic          set_max,
    input  pma_pkg::cmd_t cmd,
    output pma_pkg::sts_t sts,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [31:0]   result_address,
    output logic [1:0]    status
);

    localparam int PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int PCW = PW + 1;
    localparam int WW  = 34;
    localparam logic [WW-1:0]  PAGES_W  = WW'(PAGE_COUNT);
    localparam logic [PCW-1:0] PAGES_P  = PCW'(PAGE_COUNT);
    localparam logic [PCW-1:0] LAST_P   = PCW'(PAGE_COUNT - 1);
    localparam logic [WW-1:0]  PSIZE_M1 = WW'((64'd1 << PAGE_SIZE_LOG2) - 64'd1);

    // page table
    logic [6:0] mem [PAGE_COUNT];
    logic [6:0] rd_reg;

    logic [1:0]     type_reg;
    logic [31:0]    start_reg;
    logic [WW-1:0]  end_reg;
    logic [WW-1:0]  count_reg;
    logic [PCW-1:0] pmask_reg;
    logic           any_reg, over_reg, setmax_reg, size_zero_reg;
    logic [2:0]     prot_reg, maxp_reg;
    logic [PCW-1:0] ptr_reg, run_reg, first_reg;
    logic           ok_reg, nm_reg, pf_reg;
    logic [1:0]     res_status_reg;
    logic [31:0]    res_addr_reg;
    logic           out_valid_reg;
    logic [1:0]     out_status_reg;
    logic [31:0]    out_addr_reg;

    // request decode
    logic [WW-1:0] size_w, addr_w, cnt_w, mend_w, rend_w;
    logic [31:0]   pmask32, mstart, rstart;
    always_comb
    begin
        size_w  = {2'b00, size};
        addr_w  = {2'b00, address};
        cnt_w   = (size_w + PSIZE_M1) >> PAGE_SIZE_LOG2;
        pmask32 = align_mask >> PAGE_SIZE_LOG2;
        mstart  = (address >> PAGE_SIZE_LOG2) & ~pmask32;
        mend_w  = {2'b00, mstart} + cnt_w;
        rstart  = address >> PAGE_SIZE_LOG2;
        rend_w  = (addr_w + size_w + PSIZE_M1) >> PAGE_SIZE_LOG2;
    end

    // first-fit step on the entry just read
    logic           f_valid, ff_skip, ff_found;
    logic [PCW-1:0] run_inc, first_new;
    always_comb
    begin
        f_valid   = rd_reg[6];
        ff_skip   = !f_valid && (run_reg == '0) && ((ptr_reg & pmask_reg) != '0);
        run_inc   = run_reg + PCW'(1);
        first_new = (run_reg == '0) ? ptr_reg : first_reg;
        ff_found  = !f_valid && !ff_skip && (WW'(run_inc) == count_reg);
    end

    // write port data
    logic       wr_en;
    logic [6:0] wr_data;
    logic [2:0] cur_p, max_p;
    always_comb
    begin
        cur_p   = rd_reg[2:0];
        max_p   = rd_reg[5:3];
        wr_en   = cmd.clr_wr || cmd.map_wr || cmd.reg_wr;
        wr_data = '0;
        if (cmd.map_wr)
        begin
            wr_data = {1'b1, maxp_reg, prot_reg};
        end
        else if (cmd.reg_wr)
        begin
            if (type_reg == pma_pkg::REQ_UNMAP)
                wr_data = '0;
            else if (setmax_reg)
                wr_data = {1'b1, prot_reg,
                           ((cur_p & ~prot_reg) == 3'b000) ? cur_p : prot_reg};
            else
                wr_data = {1'b1, max_p, prot_reg};
        end
    end

    // memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[ptr_reg[PW-1:0]] <= wr_data;
        rd_reg <= mem[ptr_reg[PW-1:0]];
    end

    // request fields and region bounds
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg      <= req_type;
            count_reg     <= cnt_w;
            pmask_reg     <= pmask32[PCW-1:0];
            any_reg       <= anywhere;
            over_reg      <= overwrite;
            setmax_reg    <= set_max;
            prot_reg      <= protect;
            maxp_reg      <= max_protect;
            size_zero_reg <= (size == '0);
            if (req_type == pma_pkg::REQ_MAP)
            begin
                start_reg <= mstart;
                end_reg   <= mend_w;
            end
            else
            begin
                start_reg <= rstart;
                end_reg   <= rend_w;
            end
        end
        else if (cmd.ff_eval && ff_found)
        begin
            start_reg <= 32'(first_new);
            end_reg   <= WW'(first_new) + count_reg;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_addr_reg   <= cmd.res_addr ? (start_reg << PAGE_SIZE_LOG2) : '0;
        end
        if (cmd.push)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    // walk pointer, search and check state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            run_reg       <= '0;
            first_reg     <= '0;
            ok_reg        <= 1'b0;
            nm_reg        <= 1'b0;
            pf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ptr_start)
                ptr_reg <= PCW'(start_reg);
            else if (cmd.ptr_one)
                ptr_reg <= PCW'(1);
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + PCW'(1);

            if (cmd.ptr_one)
                run_reg <= '0;
            else if (cmd.ff_eval)
            begin
                if (f_valid)
                    run_reg <= '0;
                else if (!ff_skip)
                begin
                    first_reg <= first_new;
                    run_reg   <= run_inc;
                end
            end

            if (cmd.ok_set)
                ok_reg <= 1'b1;
            else if (cmd.ok_clr)
                ok_reg <= 1'b0;

            if (cmd.flags_clr)
            begin
                nm_reg <= 1'b0;
                pf_reg <= 1'b0;
            end
            else if (cmd.reg_eval)
            begin
                nm_reg <= nm_reg | !rd_reg[6];
                pf_reg <= pf_reg | ((prot_reg & ~max_p) != 3'b000);
            end

            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // status to controller
    always_comb
    begin
        sts.req_type    = type_reg;
        sts.size_zero   = size_zero_reg;
        sts.inrange     = (end_reg <= PAGES_W);
        sts.end_hit     = (WW'(ptr_reg) == end_reg);
        sts.ptr_last    = (ptr_reg == LAST_P);
        sts.ptr_at_n    = (ptr_reg == PAGES_P);
        sts.entry_valid = rd_reg[6];
        sts.ok          = ok_reg;
        sts.start_zero  = (start_reg == '0);
        sts.anywhere    = any_reg;
        sts.overwrite   = over_reg;
        sts.prot_ok     = ((prot_reg & ~maxp_reg) == 3'b000);
        sts.not_mapped  = nm_reg;
        sts.prot_fail   = pf_reg;
        sts.ff_found    = ff_found;
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;

endmodule

/* rtl/pma_controller.sv */
// ----------------------------------------------------------------------------
// pma_controller
// sequencer for table clearing, region checks, first-fit search and writes
// ----------------------------------------------------------------------------
module pma_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pma_pkg::sts_t sts,
    output pma_pkg::cmd_t cmd
);

    pma_pkg::state_t state_reg, state_next;
    logic            map_ok;

    // requested region usable as is
    assign map_ok = sts.ok && !(sts.start_zero && sts.anywhere);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pma_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pma_pkg::S_CLEAR:
                if (sts.ptr_last)
                    state_next = pma_pkg::S_IDLE;
            pma_pkg::S_IDLE:
                if (in_valid)
                    state_next = pma_pkg::S_DECODE;
            pma_pkg::S_DECODE:
                case (sts.req_type)
                    pma_pkg::REQ_MAP:
                        if (sts.size_zero)
                            state_next = pma_pkg::S_OUT;
                        else if (sts.inrange)
                            state_next = pma_pkg::S_MF_RD;
                        else
                            state_next = pma_pkg::S_MAP_POST;
                    pma_pkg::REQ_UNMAP, pma_pkg::REQ_PROTECT:
                        state_next = sts.inrange ? pma_pkg::S_RG_RD : pma_pkg::S_OUT;
                    default:
                        state_next = pma_pkg::S_OUT;
                endcase
            pma_pkg::S_MF_RD:
                state_next = sts.end_hit ? pma_pkg::S_MAP_POST : pma_pkg::S_MF_EV;
            pma_pkg::S_MF_EV:
                state_next = sts.entry_valid ? pma_pkg::S_MAP_POST : pma_pkg::S_MF_RD;
            pma_pkg::S_MAP_POST:
                if (map_ok)
                    state_next = pma_pkg::S_PCHK;
                else if (sts.anywhere)
                    state_next = pma_pkg::S_FF_RD;
                else if (sts.overwrite && sts.inrange)
                    state_next = pma_pkg::S_PCHK;
                else
                    state_next = pma_pkg::S_OUT;
            pma_pkg::S_FF_RD:
                // search exhausted: fall back to overwrite of the requested region if allowed and in range
                if (!sts.ptr_at_n)
                    state_next = pma_pkg::S_FF_EV;
                else if (sts.overwrite && sts.inrange)
                    state_next = pma_pkg::S_PCHK;
                else
                    state_next = pma_pkg::S_OUT;
            pma_pkg::S_FF_EV:
                state_next = sts.ff_found ? pma_pkg::S_PCHK : pma_pkg::S_FF_RD;
            pma_pkg::S_PCHK:
                state_next = sts.prot_ok ? pma_pkg::S_MW : pma_pkg::S_OUT;
            pma_pkg::S_MW:
                if (sts.end_hit)
                    state_next = pma_pkg::S_OUT;
            pma_pkg::S_RG_RD:
                state_next = sts.end_hit ? pma_pkg::S_RG_POST : pma_pkg::S_RG_EV;
            pma_pkg::S_RG_EV:
                state_next = pma_pkg::S_RG_RD;
            pma_pkg::S_RG_POST:
                if (sts.not_mapped
                    || (sts.req_type == pma_pkg::REQ_PROTECT && sts.prot_fail))
                    state_next = pma_pkg::S_OUT;
                else
                    state_next = pma_pkg::S_RW_RD;
            pma_pkg::S_RW_RD:
                state_next = sts.end_hit ? pma_pkg::S_OUT : pma_pkg::S_RW_EV;
            pma_pkg::S_RW_EV:
                state_next = pma_pkg::S_RW_RD;
            pma_pkg::S_OUT:
                if (sts.out_free)
                    state_next = pma_pkg::S_IDLE;
            default:
                state_next = pma_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd            = '0;
        cmd.res_status = pma_pkg::STS_OK;
        in_ready       = 1'b0;
        case (state_reg)
            pma_pkg::S_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.ptr_inc = 1'b1;
            end
            pma_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pma_pkg::S_DECODE:
                case (sts.req_type)
                    pma_pkg::REQ_MAP:
                        if (sts.size_zero)
                            cmd.res_set = 1'b1;
                        else if (sts.inrange)
                        begin
                            cmd.ptr_start = 1'b1;
                            cmd.ok_set    = 1'b1;
                        end
                        else
                            cmd.ok_clr = 1'b1;
                    pma_pkg::REQ_UNMAP, pma_pkg::REQ_PROTECT:
                        if (sts.inrange)
                        begin
                            cmd.ptr_start = 1'b1;
                            cmd.flags_clr = 1'b1;
                        end
                        else
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = pma_pkg::STS_INVALID;
                        end
                    default:
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = pma_pkg::STS_INVALID;
                    end
                endcase
            pma_pkg::S_MF_EV:
                if (sts.entry_valid)
                    cmd.ok_clr = 1'b1;
                else
                    cmd.ptr_inc = 1'b1;
            pma_pkg::S_MAP_POST:
                if (!map_ok)
                begin
                    if (sts.anywhere)
                        cmd.ptr_one = 1'b1;
                    else if (!(sts.overwrite && sts.inrange))
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = sts.inrange ? pma_pkg::STS_NOSPACE
                                                     : pma_pkg::STS_INVALID;
                    end
                end
            pma_pkg::S_FF_RD:
                if (sts.ptr_at_n && !(sts.overwrite && sts.inrange))
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = sts.overwrite ? pma_pkg::STS_INVALID
                                                   : pma_pkg::STS_NOSPACE;
                end
            pma_pkg::S_FF_EV:
            begin
                cmd.ff_eval = 1'b1;
                cmd.ptr_inc = 1'b1;
            end
            pma_pkg::S_PCHK:
                if (sts.prot_ok)
                    cmd.ptr_start = 1'b1;
                else
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = pma_pkg::STS_PROT;
                end
            pma_pkg::S_MW:
                if (sts.end_hit)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_addr = 1'b1;
                end
                else
                begin
                    cmd.map_wr  = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
            pma_pkg::S_RG_EV:
            begin
                cmd.reg_eval = 1'b1;
                cmd.ptr_inc  = 1'b1;
            end
            pma_pkg::S_RG_POST:
                if (sts.not_mapped)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = pma_pkg::STS_INVALID;
                end
                else if (sts.req_type == pma_pkg::REQ_PROTECT && sts.prot_fail)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = pma_pkg::STS_PROT;
                end
                else
                    cmd.ptr_start = 1'b1;
            pma_pkg::S_RW_RD:
                if (sts.end_hit)
                    cmd.res_set = 1'b1;
            pma_pkg::S_RW_EV:
            begin
                cmd.reg_wr  = 1'b1;
                cmd.ptr_inc = 1'b1;
            end
            pma_pkg::S_OUT:
                cmd.push = sts.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

/* rtl/page_map_allocator.sv */
// sequence: each region check, first-fit search and unmap or protect rewrite walks
//   the table page by page, and a map writes its pages one by one; the longest path
//   is a region check, a full search, then an overwrite of the region
// throughput: one request at a time, the next word is taken in the cycle after the result
//   word enters the output register
// reset: all pages are cleared by a pass over the table, one entry per cycle,
//   before the first request word is taken
// ----------------------------------------------------------------------------
// page_map_allocator
// first-fit aligned page allocator with map, unmap and protect requests
// ----------------------------------------------------------------------------
`include "page_map_allocator_defines.svh"

module page_map_allocator #(
    parameter int PAGE_COUNT     = pma_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SIZE_LOG2 = pma_pkg::PAGE_SIZE_LOG2_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] address,
    input  logic [31:0] size,
    input  logic [31:0] align_mask,
    input  logic        anywhere,
    input  logic        overwrite,
    input  logic [2:0]  protect,
    input  logic [2:0]  max_protect,
    input  logic        set_max,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_address,
    output logic [1:0]  status
);

    pma_pkg::cmd_t cmd;
    pma_pkg::sts_t sts;
    logic          fail_word;

    // sequencer
    pma_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table and search datapath
    pma_datapath #(
        .PAGE_COUNT     (PAGE_COUNT),
        .PAGE_SIZE_LOG2 (PAGE_SIZE_LOG2)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_type       (req_type),
        .address        (address),
        .size           (size),
        .align_mask     (align_mask),
        .anywhere       (anywhere),
        .overwrite      (overwrite),
        .protect        (protect),
        .max_protect    (max_protect),
        .set_max        (set_max),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .result_address (result_address),
        .status         (status)
    );

    // failed result word on the output
    assign fail_word = out_valid && (status != pma_pkg::STS_OK);

    // checks
    `PMA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `PMA_ASSERT_NOW(a_addr_zero_on_fail, fail_word, result_address == '0)
    `PMA_ASSERT_NOW(a_one_write_kind, 1'b1, $onehot0({cmd.clr_wr, cmd.map_wr, cmd.reg_wr}))

endmodule

/* tb/page_map_allocator_tb.sv */
// ----------------------------------------------------------------------------
// page_map_allocator_tb
// checks map, unmap and protect requests against a page table predictor,
// with a directed table first, then random request words under random
// idling on both channels
// ----------------------------------------------------------------------------
module page_map_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES = 1024;
    localparam int PLOG = 12;
    localparam logic [1:0] REQ_BAD = 2'd3;
    localparam int IDLE_LIMIT = 30000;
    localparam int DRAIN_CYCLES = 4200;
    localparam int RANDOM_WORDS = 560;
    localparam int NO_EXP = 0;
    localparam int HAS_EXP = 1;

    typedef struct {
        logic [1:0]       req;
        logic [31:0]      addr;
        logic [31:0]      size;
        logic [31:0]      mask;
        logic             any;
        logic             over;
        logic [2:0]       prot;
        logic [2:0]       maxp;
        logic             smax;
        int               typed;
        logic [31:0]      e_addr;
        pma_pkg::status_t e_sts;
    } req_word_t;

    typedef struct {
        logic [31:0]      addr;
        pma_pkg::status_t sts;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = pma_pkg::REQ_MAP;
    logic [31:0] address = '0;
    logic [31:0] size = '0;
    logic [31:0] align_mask = '0;
    logic        anywhere = 1'b0;
    logic        overwrite = 1'b0;
    logic [2:0]  protect = '0;
    logic [2:0]  max_protect = '0;
    logic        set_max = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result_address;
    logic [1:0]  status;

    // page table copy: bit 6 valid, 5..3 maximum protection, 2..0 protection
    logic [6:0]  page_tbl [PAGES];
    result_t     pending_results [$];
    req_word_t   typed_q [$];
    int          mismatches = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          sts_seen [4] = '{0, 0, 0, 0};
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;

    page_map_allocator uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit within_prot(logic [2:0] p, logic [2:0] m);
        return (p & ~m) == 3'd0;
    endfunction

    function automatic bit region_is(longint unsigned st, longint unsigned cnt, bit mapped);
        for (longint unsigned p = st; p < st + cnt; p++)
            if (page_tbl[p][6] != mapped)
                return 1'b0;
        return 1'b1;
    endfunction

    // map request: aligned start, first-fit search or overwrite fallback
    function automatic pma_pkg::status_t map_pages(req_word_t w, output logic [31:0] ra);
        longint unsigned pm, start, cnt, run, first;
        bit inr, ok;
        pm = longint'(w.mask) >> PLOG;
        start = (longint'(w.addr) >> PLOG) & ~pm;
        cnt = (longint'(w.size) + (1 << PLOG) - 1) >> PLOG;
        ra = '0;
        if (w.size == 0)
            return pma_pkg::STS_OK;
        inr = start + cnt <= PAGES;
        ok = inr ? region_is(start, cnt, 1'b0) : 1'b0;
        if (start == 0 && w.any)
            ok = 1'b0;
        if (!ok && w.any)
        begin
            run = 0;
            first = 0;
            for (longint unsigned p = 1; p < PAGES && !ok; p++)
            begin
                if (page_tbl[p][6])
                    run = 0;
                else if (run != 0 || (p & pm) == 0)
                begin
                    if (run == 0)
                        first = p;
                    run++;
                    if (run == cnt)
                    begin
                        start = first;
                        ok = 1'b1;
                    end
                end
            end
        end
        if (!ok && w.over)
        begin
            if (!inr)
                return pma_pkg::STS_INVALID;
            ok = 1'b1;
        end
        if (!ok)
            return (!inr && !w.any) ? pma_pkg::STS_INVALID : pma_pkg::STS_NOSPACE;
        if (!within_prot(w.prot, w.maxp))
            return pma_pkg::STS_PROT;
        for (longint unsigned p = start; p < start + cnt; p++)
            page_tbl[p] = {1'b1, w.maxp, w.prot};
        ra = 32'(start << PLOG);
        return pma_pkg::STS_OK;
    endfunction

    // unmap or protect over a fully mapped region
    function automatic pma_pkg::status_t region_update(req_word_t w, bit is_prot);
        longint unsigned start, stop;
        logic [2:0] cur, mx;
        start = longint'(w.addr) >> PLOG;
        stop = (longint'(w.addr) + longint'(w.size) + (1 << PLOG) - 1) >> PLOG;
        if (stop > PAGES)
            return pma_pkg::STS_INVALID;
        if (!region_is(start, stop - start, 1'b1))
            return pma_pkg::STS_INVALID;
        if (!is_prot)
        begin
            for (longint unsigned p = start; p < stop; p++)
                page_tbl[p] = '0;
            return pma_pkg::STS_OK;
        end
        for (longint unsigned p = start; p < stop; p++)
            if (!within_prot(w.prot, page_tbl[p][5:3]))
                return pma_pkg::STS_PROT;
        for (longint unsigned p = start; p < stop; p++)
        begin
            cur = page_tbl[p][2:0];
            mx = page_tbl[p][5:3];
            if (w.smax)
            begin
                mx = w.prot;
                if (!within_prot(cur, mx))
                    cur = mx;
            end
            else
                cur = w.prot;
            page_tbl[p] = {1'b1, mx, cur};
        end
        return pma_pkg::STS_OK;
    endfunction

    function automatic result_t predict_result(req_word_t w);
        result_t r;
        r.addr = '0;
        case (w.req)
            pma_pkg::REQ_MAP:     r.sts = map_pages(w, r.addr);
            pma_pkg::REQ_UNMAP:   r.sts = region_update(w, 1'b0);
            pma_pkg::REQ_PROTECT: r.sts = region_update(w, 1'b1);
            default:              r.sts = pma_pkg::STS_INVALID;
        endcase
        return r;
    endfunction

    // accepted request word: update predictor, queue expected result
    always @(posedge clk)
    begin
        req_word_t w;
        result_t   r;
        if (rst_n && in_valid && in_ready)
        begin
            w = typed_q.pop_front();
            r = predict_result(w);
            if (w.typed == HAS_EXP)
            begin
                r.addr = w.e_addr;
                r.sts = w.e_sts;
            end
            pending_results.push_back(r);
            words_in++;
        end
    end

    // result word check
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && out_valid && out_ready)
        begin
            words_out++;
            sts_seen[status]++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word addr=%h status=%0d",
                             result_address, status);
            end
            else
            begin
                r = pending_results.pop_front();
                if (result_address !== r.addr || status !== r.sts)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected addr=%h status=%0d, got addr=%h status=%0d",
                                 words_out, r.addr, r.sts, result_address, status);
                end
            end
        end
    end

    // receiver: one long hold-off on request, otherwise its own stall pattern
    always @(posedge clk)
    begin
        int hold_left;
        int phase;
        bit hold_done;
        if (hold_req && !hold_done)
        begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            phase = (phase + 1) % 200;
            out_ready <= (phase < 60) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(req_word_t w);
        typed_q.push_back(w);
        in_valid <= 1'b1;
        req_type <= w.req;
        address <= w.addr;
        size <= w.size;
        align_mask <= w.mask;
        anywhere <= w.any;
        overwrite <= w.over;
        protect <= w.prot;
        max_protect <= w.maxp;
        set_max <= w.smax;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic req_word_t mk(logic [1:0] rq, logic [31:0] a, logic [31:0] s,
                                     logic [31:0] m, logic an, logic ov, logic [2:0] p,
                                     logic [2:0] mp, logic sm, int ty,
                                     logic [31:0] ea, pma_pkg::status_t es);
        req_word_t w;
        w = '{rq, a, s, m, an, ov, p, mp, sm, ty, ea, es};
        return w;
    endfunction

    // random request: mostly small in-range regions, some raw 32-bit values
    function automatic req_word_t random_word();
        req_word_t w;
        int sel;
        int pg;
        w = mk(pma_pkg::REQ_MAP, '0, '0, '0, 0, 0, '0, '0, 0, NO_EXP, '0, pma_pkg::STS_OK);
        sel = $urandom_range(0, 99);
        w.req = (sel < 50) ? pma_pkg::REQ_MAP :
                (sel < 72) ? pma_pkg::REQ_UNMAP :
                (sel < 97) ? pma_pkg::REQ_PROTECT : REQ_BAD;
        pg = $urandom_range(0, PAGES + 40);
        if (w.req != pma_pkg::REQ_MAP && $urandom_range(0, 3) != 0)
        begin
            // aim at a mapped page so the region checks pass often
            for (int t = 0; t < 8; t++)
            begin
                pg = $urandom_range(0, PAGES - 1);
                if (page_tbl[pg][6])
                    break;
            end
        end
        w.addr = (32'(pg) << PLOG) | ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : 0);
        w.size = $urandom_range(0, 4 << PLOG);
        if ($urandom_range(0, 19) == 0)
            w.addr = $urandom;
        if ($urandom_range(0, 19) == 0)
            w.size = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    w.mask = ((32'd1 << $urandom_range(0, 4)) - 1) << PLOG;
            2:       w.mask = $urandom;
            default: w.mask = $urandom_range(0, 4095);
        endcase
        w.any = $urandom_range(0, 3) != 0;
        w.over = $urandom_range(0, 5) == 0;
        w.maxp = 3'($urandom_range(0, 7));
        w.prot = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : (w.maxp & 3'($urandom));
        w.smax = $urandom_range(0, 2) == 0;
        return w;
    endfunction

    initial
    begin
        req_word_t dir_rows [$];
        req_word_t w;
        int gap;
        int burst;

        foreach (page_tbl[i])
            page_tbl[i] = '0;

        dir_rows = '{
            mk(pma_pkg::REQ_MAP, 32'h0000_5000, 32'd0, 0, 0, 0, 3'd7, 3'd7, 0, HAS_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_MAP, 32'h0000_0000, 32'd4096, 0, 0, 0, 3'd7, 3'd7, 0, HAS_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_UNMAP, 32'h001F_4000, 32'd4096, 0, 0, 0, 0, 0, 0, HAS_EXP, 0,
               pma_pkg::STS_INVALID),
            mk(REQ_BAD, 32'h0000_1000, 32'd4096, 0, 1, 1, 3'd7, 3'd7, 1, HAS_EXP, 0,
               pma_pkg::STS_INVALID),
            mk(pma_pkg::REQ_MAP, 32'hFFFF_F000, 32'd8192, 0, 0, 0, 3'd1, 3'd1, 0, HAS_EXP, 0,
               pma_pkg::STS_INVALID),
            mk(pma_pkg::REQ_MAP, 32'h0000_A000, 32'd1, 0, 0, 0, 3'd7, 3'd3, 0, HAS_EXP, 0,
               pma_pkg::STS_PROT),
            mk(pma_pkg::REQ_MAP, 32'hFFFF_F000, 32'd8192, 0, 0, 1, 3'd1, 3'd1, 0, HAS_EXP, 0,
               pma_pkg::STS_INVALID),
            mk(pma_pkg::REQ_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1, 0, 3'd1, 3'd7, 0, HAS_EXP,
               0, pma_pkg::STS_NOSPACE),
            mk(pma_pkg::REQ_UNMAP, 32'h0030_0000, 32'd0, 0, 0, 0, 0, 0, 0, HAS_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_PROTECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 3'd7, 0, 1, HAS_EXP,
               0, pma_pkg::STS_INVALID),
            mk(pma_pkg::REQ_MAP, 32'h0000_0000, 32'd8192, 0, 1, 0, 3'd5, 3'd7, 0, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_MAP, 32'h0000_0000, 32'd4096, 32'h0000_3FFF, 1, 0, 3'd3, 3'd3, 0,
               NO_EXP, 0, pma_pkg::STS_OK),
            mk(pma_pkg::REQ_MAP, 32'h0000_0FFF, 32'd12288, 0, 0, 1, 3'd6, 3'd6, 0, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_MAP, 32'h0000_2000, 32'd4096, 32'hFFFF_FFFF, 1, 0, 3'd0, 3'd0, 0,
               NO_EXP, 0, pma_pkg::STS_OK),
            mk(pma_pkg::REQ_PROTECT, 32'h0000_0000, 32'd4096, 0, 0, 0, 3'd7, 0, 0, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_PROTECT, 32'h0000_1000, 32'd4096, 0, 0, 0, 3'd7, 0, 0, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_PROTECT, 32'h0000_0000, 32'd4096, 0, 0, 0, 3'd1, 0, 1, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_PROTECT, 32'h0000_0000, 32'd4096, 0, 0, 0, 3'd7, 0, 1, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_PROTECT, 32'h0000_0800, 32'd8192, 0, 0, 0, 3'd2, 0, 0, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_UNMAP, 32'h0000_1000, 32'd4096, 0, 0, 0, 0, 0, 0, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_UNMAP, 32'h0000_0000, 32'd16384, 0, 0, 0, 0, 0, 0, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_MAP, 32'h003F_F000, 32'd4096, 0, 0, 0, 3'd4, 3'd4, 0, NO_EXP, 0,
               pma_pkg::STS_OK),
            mk(pma_pkg::REQ_UNMAP, 32'h003F_F000, 32'd4096, 0, 0, 0, 0, 0, 0, NO_EXP, 0,
               pma_pkg::STS_OK)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i])
            send(dir_rows[i]);
        in_valid <= 1'b0;

        // full drain before the random part
        @(posedge clk);
        wait (pending_results.size() == 0);
        @(posedge clk);

        // random bursts with gaps
        burst = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 150)
                hold_req = 1'b1;
            if (n == 153)
                hold_req = 1'b0;
            w = random_word();
            send(w);
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            else
                burst--;
            if (n == 300)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending_results.size() == 0);
                @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d request words and %0d result words", words_in, words_out);
        $display("status ok=%0d nospace=%0d invalid=%0d prot=%0d", sts_seen[0], sts_seen[1],
                 sts_seen[2], sts_seen[3]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* page_map_allocator.f */
+incdir+rtl
rtl/pma_pkg.sv
rtl/pma_datapath.sv
rtl/pma_controller.sv
rtl/page_map_allocator.sv
tb/page_map_allocator_tb.sv
